// ===== sv/scr_pkg.sv =====
// scr_pkg: widths, field offsets and the in-flight item type of the spring relax pipeline
// no dependencies; used by spring_consensus_relax and tb_top
`default_nettype none
package scr_pkg;

    localparam int COORD_BITS      = 16;
    localparam int COORD_FRAC_BITS = 10;
    localparam int GAIN_BITS       = 24;
    localparam int GAIN_FRAC_BITS  = 12;
    localparam int NORM_EXTRA_BITS = 8;

    localparam int VEC_BITS = 3 * COORD_BITS;

    // input word layout, lowest bit first
    localparam int GF_LSB  = 0;
    localparam int GS_LSB  = VEC_BITS;
    localparam int TF_LSB  = 2 * VEC_BITS;
    localparam int TS_LSB  = 3 * VEC_BITS;
    localparam int RHO_LSB = 4 * VEC_BITS;
    localparam int K_LSB   = 4 * VEC_BITS + GAIN_BITS;
    localparam int L_LSB   = 4 * VEC_BITS + 2 * GAIN_BITS;
    localparam int IN_RAW  = 4 * VEC_BITS + 3 * GAIN_BITS;
    localparam int IN_BITS = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW  = 2 * VEC_BITS;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    // datapath widths
    localparam int DE_BITS   = COORD_BITS + 2;
    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int RAD_BITS  = SUM_BITS + 2 * NORM_EXTRA_BITS;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int KL_BITS   = 2 * GAIN_BITS;
    localparam int KL_SHIFT  = COORD_FRAC_BITS + NORM_EXTRA_BITS + 1 - GAIN_FRAC_BITS;
    localparam int RR_BITS   = GAIN_BITS + ROOT_BITS;
    localparam int NUM_A     = KL_BITS + KL_SHIFT;
    localparam int NUM_BITS  = ((NUM_A > RR_BITS) ? NUM_A : RR_BITS) + 1;
    localparam int NUM_LO    = NUM_BITS / 2;
    localparam int NUM_HI    = NUM_BITS - NUM_LO;
    // 2k + rho reaches three times the largest gain
    localparam int DEN_BITS  = GAIN_BITS + 2;
    localparam int DIV_BITS  = DEN_BITS + ROOT_BITS;
    localparam int PROD_BITS = NUM_BITS + MAG_BITS;
    // quotient bits kept; one at or above 2^QUO_BITS saturates both outputs on its axis
    localparam int QUO_BITS  = COORD_BITS + 3;
    localparam int REM_MIN   = DIV_BITS + QUO_BITS + 1;
    localparam int REM_BITS  = (PROD_BITS > REM_MIN) ? PROD_BITS : REM_MIN;
    localparam int OFF_BITS  = QUO_BITS + 2;
    localparam int SUMX_BITS = OFF_BITS + 1;

    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

    typedef struct packed {
        logic [2:0][DE_BITS-1:0]  c2;
        logic [2:0][MAG_BITS-1:0] mag;
        logic [2:0]               neg;
        logic                     zero_off;
        logic                     fault;
        logic [KL_BITS-1:0]       kl;
        logic [GAIN_BITS-1:0]     rho;
        logic [DEN_BITS-1:0]      den;
    } item_t;

endpackage
`default_nettype wire

// ===== sv/spring_consensus_relax.sv =====
// spring_consensus_relax: pipelined proximal step of a two-point spring
// depends on scr_pkg (widths, field offsets, item_t)
//
// usage:
//   s_ channel carries one spring per word; m_ channel returns the two relaxed
//   endpoints per word, with the divide fault and saturation flags in m_tuser.
//   a word is taken when tvalid and tready are both high.
// throughput: one spring per cycle while the receiver keeps m_tready high.
// depth: set by the 26-step square root and the 19-step restoring dividers, one
//   step per pipeline stage, plus the difference, square, norm, multiply, range
//   check, round, halve and clamp stages.
// stall: every stage advances only while the output register is empty or being
//   taken, so s_tready follows that condition; a stalled word holds in place and
//   nothing is dropped or repeated.
// reset: aresetn low clears all stage valid bits; the pipeline comes out empty.
// math: e = target - gap per endpoint, de = e1 - e2, r = sqrt(|de|^2 * 2^16),
//   offset = round((k*L*2^7 + rho*r) * |de| / ((2k + rho) * r)) per coordinate,
//   outputs are (e1 + e2 +/- offset) halved with round up, clamped to range.
`default_nettype none
module spring_consensus_relax (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // gap_first, gap_second, target_first, target_second, penalty, stiffness,
    // rest_length
    input  wire  [scr_pkg::IN_BITS-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // relaxed_first, relaxed_second
    output logic [scr_pkg::OUT_BITS-1:0] m_tdata,
    // divide_fault, saturated
    output logic [1:0]                   m_tuser
);

    localparam int C    = scr_pkg::COORD_BITS;
    localparam int NRT  = scr_pkg::ROOT_BITS;
    localparam int NQ   = scr_pkg::QUO_BITS;
    localparam int RADB = scr_pkg::RAD_BITS;
    localparam int REMB = scr_pkg::REM_BITS;

    logic adv;

    // output register
    logic                          out_vld_reg;
    logic [scr_pkg::OUT_BITS-1:0]  out_data_reg;
    logic [1:0]                    out_user_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- stage 1: differences, denominator, k*L ----------------
    scr_pkg::item_t st1_next, st1_reg;
    logic           st1_vld_reg;

    always_comb begin
        logic signed [scr_pkg::DE_BITS-1:0] e1, e2, de;
        logic [scr_pkg::GAIN_BITS-1:0]      k, len;
        k   = s_tdata[scr_pkg::K_LSB +: scr_pkg::GAIN_BITS];
        len = s_tdata[scr_pkg::L_LSB +: scr_pkg::GAIN_BITS];
        st1_next     = '0;
        st1_next.rho = s_tdata[scr_pkg::RHO_LSB +: scr_pkg::GAIN_BITS];
        for (int a = 0; a < 3; a++) begin
            e1 = scr_pkg::DE_BITS'($signed(s_tdata[scr_pkg::TF_LSB + a*C +: C]))
               - scr_pkg::DE_BITS'($signed(s_tdata[scr_pkg::GF_LSB + a*C +: C]));
            e2 = scr_pkg::DE_BITS'($signed(s_tdata[scr_pkg::TS_LSB + a*C +: C]))
               - scr_pkg::DE_BITS'($signed(s_tdata[scr_pkg::GS_LSB + a*C +: C]));
            de = e1 - e2;
            st1_next.c2[a]  = e1 + e2;
            st1_next.neg[a] = de[scr_pkg::DE_BITS-1];
            st1_next.mag[a] = de[scr_pkg::DE_BITS-1] ? scr_pkg::MAG_BITS'(-de)
                                                     : scr_pkg::MAG_BITS'(de);
        end
        st1_next.den   = (scr_pkg::DEN_BITS'(k) << 1) + scr_pkg::DEN_BITS'(st1_next.rho);
        st1_next.kl    = scr_pkg::KL_BITS'(k) * scr_pkg::KL_BITS'(len);
        st1_next.fault = (st1_next.den == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (adv) begin
            st1_vld_reg <= s_tvalid;
        end
        if (adv) begin
            st1_reg <= st1_next;
        end
    end

    // ---------------- stage 2: squares ----------------
    scr_pkg::item_t                    st2_reg;
    logic                              st2_vld_reg;
    logic [2:0][scr_pkg::SQ_BITS-1:0]  sq2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_vld_reg <= 1'b0;
        end else if (adv) begin
            st2_vld_reg <= st1_vld_reg;
        end
        if (adv) begin
            st2_reg <= st1_reg;
            for (int a = 0; a < 3; a++) begin
                sq2_reg[a] <= scr_pkg::SQ_BITS'(st1_reg.mag[a]) * scr_pkg::SQ_BITS'(st1_reg.mag[a]);
            end
        end
    end

    // ---------------- stage 3: squared norm, offset enable ----------------
    scr_pkg::item_t              st3_next, st3_reg;
    logic                        st3_vld_reg;
    logic [RADB-1:0]             rad3_reg;
    logic [scr_pkg::SUM_BITS-1:0] norm2;

    assign norm2 = scr_pkg::SUM_BITS'(sq2_reg[0]) + scr_pkg::SUM_BITS'(sq2_reg[1])
                 + scr_pkg::SUM_BITS'(sq2_reg[2]);

    always_comb begin
        st3_next          = st2_reg;
        st3_next.zero_off = st2_reg.fault || (st2_reg.rho == '0) || (norm2 == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_vld_reg <= 1'b0;
        end else if (adv) begin
            st3_vld_reg <= st2_vld_reg;
        end
        if (adv) begin
            st3_reg  <= st3_next;
            rad3_reg <= RADB'(norm2) << (2 * scr_pkg::NORM_EXTRA_BITS);
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    scr_pkg::item_t  sr_it_reg  [NRT];
    logic            sr_vld_reg [NRT];
    logic [RADB-1:0] sr_v_reg   [NRT];
    logic [RADB-1:0] sr_res_reg [NRT];

    for (genvar j = 0; j < NRT; j++) begin : g_sqrt
        localparam logic [RADB-1:0] BITV = RADB'(1) << (RADB - 2 - 2*j);
        scr_pkg::item_t  in_it;
        logic            in_vld;
        logic [RADB-1:0] in_v, in_res, trial;

        if (j == 0) begin : g_first
            assign in_it  = st3_reg;
            assign in_vld = st3_vld_reg;
            assign in_v   = rad3_reg;
            assign in_res = '0;
        end else begin : g_next
            assign in_it  = sr_it_reg[j-1];
            assign in_vld = sr_vld_reg[j-1];
            assign in_v   = sr_v_reg[j-1];
            assign in_res = sr_res_reg[j-1];
        end

        assign trial = in_res + BITV;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sr_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                sr_vld_reg[j] <= in_vld;
            end
            if (adv) begin
                sr_it_reg[j] <= in_it;
                if (in_v >= trial) begin
                    sr_v_reg[j]   <= in_v - trial;
                    sr_res_reg[j] <= (in_res >> 1) + BITV;
                end else begin
                    sr_v_reg[j]   <= in_v;
                    sr_res_reg[j] <= in_res >> 1;
                end
            end
        end
    end

    logic [NRT-1:0] root;
    assign root = sr_res_reg[NRT-1][NRT-1:0];

    // ---------------- m1: rho*r and divisor (2k+rho)*r ----------------
    scr_pkg::item_t               m1_it_reg;
    logic                         m1_vld_reg;
    logic [scr_pkg::RR_BITS-1:0]  m1_rr_reg;
    logic [scr_pkg::DIV_BITS-1:0] m1_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (adv) begin
            m1_vld_reg <= sr_vld_reg[NRT-1];
        end
        if (adv) begin
            m1_it_reg <= sr_it_reg[NRT-1];
            m1_rr_reg <= scr_pkg::RR_BITS'(sr_it_reg[NRT-1].rho) * scr_pkg::RR_BITS'(root);
            m1_b_reg  <= scr_pkg::DIV_BITS'(sr_it_reg[NRT-1].den) * scr_pkg::DIV_BITS'(root);
        end
    end

    // ---------------- m2: numerator ----------------
    scr_pkg::item_t               m2_it_reg;
    logic                         m2_vld_reg;
    logic [scr_pkg::NUM_BITS-1:0] m2_num_reg;
    logic [scr_pkg::DIV_BITS-1:0] m2_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (adv) begin
            m2_vld_reg <= m1_vld_reg;
        end
        if (adv) begin
            m2_it_reg  <= m1_it_reg;
            m2_b_reg   <= m1_b_reg;
            m2_num_reg <= (scr_pkg::NUM_BITS'(m1_it_reg.kl) << scr_pkg::KL_SHIFT)
                        + scr_pkg::NUM_BITS'(m1_rr_reg);
        end
    end

    // ---------------- m3: numerator times |de|, two partial products ----------------
    localparam int PLO = scr_pkg::NUM_LO + scr_pkg::MAG_BITS;
    localparam int PHI = scr_pkg::NUM_HI + scr_pkg::MAG_BITS;

    scr_pkg::item_t               m3_it_reg;
    logic                         m3_vld_reg;
    logic [scr_pkg::DIV_BITS-1:0] m3_b_reg;
    logic [2:0][PLO-1:0]          m3_lo_reg;
    logic [2:0][PHI-1:0]          m3_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_vld_reg <= 1'b0;
        end else if (adv) begin
            m3_vld_reg <= m2_vld_reg;
        end
        if (adv) begin
            m3_it_reg <= m2_it_reg;
            m3_b_reg  <= m2_b_reg;
            for (int a = 0; a < 3; a++) begin
                m3_lo_reg[a] <= PLO'(m2_num_reg[scr_pkg::NUM_LO-1:0]) * PLO'(m2_it_reg.mag[a]);
                m3_hi_reg[a] <= PHI'(m2_num_reg[scr_pkg::NUM_BITS-1:scr_pkg::NUM_LO])
                              * PHI'(m2_it_reg.mag[a]);
            end
        end
    end

    // ---------------- m4: combine partial products ----------------
    scr_pkg::item_t               m4_it_reg;
    logic                         m4_vld_reg;
    logic [scr_pkg::DIV_BITS-1:0] m4_b_reg;
    logic [2:0][REMB-1:0]         m4_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_vld_reg <= 1'b0;
        end else if (adv) begin
            m4_vld_reg <= m3_vld_reg;
        end
        if (adv) begin
            m4_it_reg <= m3_it_reg;
            m4_b_reg  <= m3_b_reg;
            for (int a = 0; a < 3; a++) begin
                m4_p_reg[a] <= REMB'(m3_lo_reg[a]) + (REMB'(m3_hi_reg[a]) << scr_pkg::NUM_LO);
            end
        end
    end

    // ---------------- d0: quotient range check ----------------
    scr_pkg::item_t               d0_it_reg;
    logic                         d0_vld_reg;
    logic [scr_pkg::DIV_BITS-1:0] d0_b_reg;
    logic [2:0][REMB-1:0]         d0_rem_reg;
    logic [2:0]                   d0_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_vld_reg <= 1'b0;
        end else if (adv) begin
            d0_vld_reg <= m4_vld_reg;
        end
        if (adv) begin
            d0_it_reg  <= m4_it_reg;
            d0_b_reg   <= m4_b_reg;
            d0_rem_reg <= m4_p_reg;
            for (int a = 0; a < 3; a++) begin
                d0_ovf_reg[a] <= m4_p_reg[a] >= (REMB'(m4_b_reg) << NQ);
            end
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    scr_pkg::item_t               dv_it_reg  [NQ];
    logic                         dv_vld_reg [NQ];
    logic [scr_pkg::DIV_BITS-1:0] dv_b_reg   [NQ];
    logic [2:0][REMB-1:0]         dv_rem_reg [NQ];
    logic [2:0][NQ-1:0]           dv_q_reg   [NQ];
    logic [2:0]                   dv_ovf_reg [NQ];

    for (genvar i = 0; i < NQ; i++) begin : g_div
        localparam int P = NQ - 1 - i;
        scr_pkg::item_t               in_it;
        logic                         in_vld;
        logic [scr_pkg::DIV_BITS-1:0] in_b;
        logic [2:0][REMB-1:0]         in_rem;
        logic [2:0][NQ-1:0]           in_q;
        logic [2:0]                   in_ovf;
        logic [REMB-1:0]              sh;

        if (i == 0) begin : g_first
            assign in_it  = d0_it_reg;
            assign in_vld = d0_vld_reg;
            assign in_b   = d0_b_reg;
            assign in_rem = d0_rem_reg;
            assign in_q   = '0;
            assign in_ovf = d0_ovf_reg;
        end else begin : g_next
            assign in_it  = dv_it_reg[i-1];
            assign in_vld = dv_vld_reg[i-1];
            assign in_b   = dv_b_reg[i-1];
            assign in_rem = dv_rem_reg[i-1];
            assign in_q   = dv_q_reg[i-1];
            assign in_ovf = dv_ovf_reg[i-1];
        end

        assign sh = REMB'(in_b) << P;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[i] <= in_vld;
            end
            if (adv) begin
                dv_it_reg[i]  <= in_it;
                dv_b_reg[i]   <= in_b;
                dv_ovf_reg[i] <= in_ovf;
                for (int a = 0; a < 3; a++) begin
                    if (in_rem[a] >= sh) begin
                        dv_rem_reg[i][a] <= in_rem[a] - sh;
                        dv_q_reg[i][a]   <= in_q[a] | (NQ'(1) << P);
                    end else begin
                        dv_rem_reg[i][a] <= in_rem[a];
                        dv_q_reg[i][a]   <= in_q[a];
                    end
                end
            end
        end
    end

    // ---------------- round half up, cap, sign ----------------
    scr_pkg::item_t                    rd_it_reg;
    logic                              rd_vld_reg;
    logic [2:0][scr_pkg::OFF_BITS-1:0] rd_off_reg;

    always_ff @(posedge aclk) begin
        logic [NQ:0] qr;
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (adv) begin
            rd_vld_reg <= dv_vld_reg[NQ-1];
        end
        if (adv) begin
            rd_it_reg <= dv_it_reg[NQ-1];
            for (int a = 0; a < 3; a++) begin
                qr = (NQ+1)'(dv_q_reg[NQ-1][a])
                   + (NQ+1)'((dv_rem_reg[NQ-1][a] << 1) >= REMB'(dv_b_reg[NQ-1]));
                if (dv_ovf_reg[NQ-1][a]) begin
                    qr = (NQ+1)'(1) << NQ;
                end
                if (dv_it_reg[NQ-1].zero_off) begin
                    qr = '0;
                end
                rd_off_reg[a] <= dv_it_reg[NQ-1].neg[a] ? -scr_pkg::OFF_BITS'(qr)
                                                         : scr_pkg::OFF_BITS'(qr);
            end
        end
    end

    // ---------------- midpoint plus and minus offset, halved rounding up ----------------
    scr_pkg::item_t                     hf_it_reg;
    logic                               hf_vld_reg;
    logic [2:0][scr_pkg::SUMX_BITS-1:0] hf_p_reg, hf_m_reg;

    always_ff @(posedge aclk) begin
        logic signed [scr_pkg::SUMX_BITS-1:0] c2x, ofx, sp, sm;
        if (!aresetn) begin
            hf_vld_reg <= 1'b0;
        end else if (adv) begin
            hf_vld_reg <= rd_vld_reg;
        end
        if (adv) begin
            hf_it_reg <= rd_it_reg;
            for (int a = 0; a < 3; a++) begin
                c2x = scr_pkg::SUMX_BITS'($signed(rd_it_reg.c2[a]));
                ofx = scr_pkg::SUMX_BITS'($signed(rd_off_reg[a]));
                sp  = c2x + ofx + scr_pkg::SUMX_BITS'(1);
                sm  = c2x - ofx + scr_pkg::SUMX_BITS'(1);
                hf_p_reg[a] <= sp >>> 1;
                hf_m_reg[a] <= sm >>> 1;
            end
        end
    end

    // ---------------- clamp and pack into the output register ----------------
    localparam logic signed [scr_pkg::SUMX_BITS-1:0] HI_X = scr_pkg::SUMX_BITS'(scr_pkg::COORD_MAX);
    localparam logic signed [scr_pkg::SUMX_BITS-1:0] LO_X = scr_pkg::SUMX_BITS'(scr_pkg::COORD_MIN);

    always_ff @(posedge aclk) begin
        logic signed [scr_pkg::SUMX_BITS-1:0] vp, vm;
        logic [scr_pkg::VEC_BITS-1:0]         o1, o2;
        logic                                 sat;
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= hf_vld_reg;
        end
        if (adv) begin
            sat = 1'b0;
            o1  = '0;
            o2  = '0;
            for (int a = 0; a < 3; a++) begin
                vp = $signed(hf_p_reg[a]);
                vm = $signed(hf_m_reg[a]);
                if (vp > HI_X) begin
                    vp  = HI_X;
                    sat = 1'b1;
                end else if (vp < LO_X) begin
                    vp  = LO_X;
                    sat = 1'b1;
                end
                if (vm > HI_X) begin
                    vm  = HI_X;
                    sat = 1'b1;
                end else if (vm < LO_X) begin
                    vm  = LO_X;
                    sat = 1'b1;
                end
                o1[a*C +: C] = vp[C-1:0];
                o2[a*C +: C] = vm[C-1:0];
            end
            out_data_reg <= scr_pkg::OUT_BITS'({o2, o1});
            out_user_reg <= {sat, hf_it_reg.fault};
        end
    end

`ifndef SYNTHESIS
    // a faulted word carries no offset, so both endpoints sit on the midpoint
    a_fault_midpoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[scr_pkg::VEC_BITS-1:0] == m_tdata[2*scr_pkg::VEC_BITS-1:scr_pkg::VEC_BITS]))
        else $error("divide fault word with nonzero offset");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a stalled output word holds until it is taken
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output word changed");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for spring_consensus_relax, a stream-in stream-out spring relax step
// depends on scr_pkg and spring_consensus_relax; predicts each result word and checks it in order
`default_nettype none
module tb_top;

    localparam int IN_BITS         = scr_pkg::IN_BITS;
    localparam int OUT_BITS        = scr_pkg::OUT_BITS;
    localparam int VEC_BITS        = scr_pkg::VEC_BITS;
    localparam int COORD_BITS      = scr_pkg::COORD_BITS;
    localparam int COORD_FRAC_BITS = scr_pkg::COORD_FRAC_BITS;
    localparam int GAIN_BITS       = scr_pkg::GAIN_BITS;
    localparam int GAIN_FRAC_BITS  = scr_pkg::GAIN_FRAC_BITS;
    localparam int NORM_EXTRA_BITS = scr_pkg::NORM_EXTRA_BITS;
    localparam int GF_LSB          = scr_pkg::GF_LSB;
    localparam int GS_LSB          = scr_pkg::GS_LSB;
    localparam int TF_LSB          = scr_pkg::TF_LSB;
    localparam int TS_LSB          = scr_pkg::TS_LSB;
    localparam int RHO_LSB         = scr_pkg::RHO_LSB;
    localparam int K_LSB           = scr_pkg::K_LSB;
    localparam int L_LSB           = scr_pkg::L_LSB;
    localparam int COORD_MAX       = scr_pkg::COORD_MAX;
    localparam int COORD_MIN       = scr_pkg::COORD_MIN;

    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic [1:0] m_tuser;

    typedef struct packed {
        logic [VEC_BITS-1:0] first;
        logic [VEC_BITS-1:0] second;
        logic                fault;
        logic                sat;
    } relaxed_t;

    relaxed_t relaxed_q[$];
    int errors = 0;
    int checked = 0;
    int sent = 0;
    int cycle = 0;
    int rx_hold = 0;
    bit rx_long = 0;

    spring_consensus_relax dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint coord_of(logic [VEC_BITS-1:0] v, int a);
        logic signed [COORD_BITS-1:0] c;
        c = v[a*COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    function automatic longint halve_up(longint v);
        longint t;
        t = v + 1;
        if (t >= 0) return t / 2;
        return -((-t + 1) / 2);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(longint v, ref logic sat);
        if (v > COORD_MAX) begin
            sat = 1'b1;
            return COORD_BITS'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            sat = 1'b1;
            return COORD_BITS'(COORD_MIN);
        end
        return v[COORD_BITS-1:0];
    endfunction

    // predicted relaxed endpoints of one spring
    function automatic relaxed_t relax_spring(logic [IN_BITS-1:0] w);
        relaxed_t res;
        logic [GAIN_BITS-1:0] rho, k, len;
        logic [63:0] den, s, r, mag;
        logic [255:0] num, dv, prod, q, rm;
        longint de[3], c2[3], off[3];
        logic sat;
        rho = w[RHO_LSB +: GAIN_BITS];
        k   = w[K_LSB +: GAIN_BITS];
        len = w[L_LSB +: GAIN_BITS];
        den = 2 * 64'(k) + 64'(rho);
        s = 0;
        sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            longint e1, e2;
            e1 = coord_of(w[TF_LSB +: VEC_BITS], a) - coord_of(w[GF_LSB +: VEC_BITS], a);
            e2 = coord_of(w[TS_LSB +: VEC_BITS], a) - coord_of(w[GS_LSB +: VEC_BITS], a);
            de[a] = e1 - e2;
            c2[a] = e1 + e2;
            off[a] = 0;
            s += 64'(de[a] * de[a]);
        end
        if (den != 0 && rho != 0 && s != 0) begin
            logic [63:0] v;
            v = s << (2 * NORM_EXTRA_BITS);
            r = 0;
            // integer square root by bisection on the result bits
            for (int b = 31; b >= 0; b--) begin
                logic [63:0] t;
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            num = (256'(k) * 256'(len) << (COORD_FRAC_BITS + NORM_EXTRA_BITS + 1))
                + (256'(rho) * 256'(r) << GAIN_FRAC_BITS);
            dv = (256'(den) * 256'(r)) << GAIN_FRAC_BITS;
            for (int a = 0; a < 3; a++) begin
                mag = 64'(de[a] < 0 ? -de[a] : de[a]);
                prod = num * 256'(mag);
                q = prod / dv;
                rm = prod % dv;
                if ((rm << 1) >= dv) q = q + 1;
                if (q > (256'd1 << 40)) q = 256'd1 << 40;
                off[a] = de[a] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
        end
        for (int a = 0; a < 3; a++) begin
            res.first[a*COORD_BITS +: COORD_BITS]  = clamp_coord(halve_up(c2[a] + off[a]), sat);
            res.second[a*COORD_BITS +: COORD_BITS] = clamp_coord(halve_up(c2[a] - off[a]), sat);
        end
        res.fault = (den == 0);
        res.sat = sat;
        return res;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // sender: one word per handshake, random gaps before it
    task automatic send_spring(logic [IN_BITS-1:0] w);
        int g;
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        relaxed_q.push_back(relax_spring(w));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // drop valid after the last word of a sequence
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [VEC_BITS-1:0] rnd_vec(int spread);
        logic [VEC_BITS-1:0] v;
        for (int a = 0; a < 3; a++) begin
            if (spread == 0) v[a*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
            else v[a*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom_range(0, 2*spread) - spread);
        end
        return v;
    endfunction

    function automatic logic [IN_BITS-1:0] pack_spring(logic [VEC_BITS-1:0] y1, y2, z1, z2,
                                                       logic [GAIN_BITS-1:0] rho, k, len);
        logic [IN_BITS-1:0] w;
        w = '0;
        w[GF_LSB +: VEC_BITS] = y1;
        w[GS_LSB +: VEC_BITS] = y2;
        w[TF_LSB +: VEC_BITS] = z1;
        w[TS_LSB +: VEC_BITS] = z2;
        w[RHO_LSB +: GAIN_BITS] = rho;
        w[K_LSB +: GAIN_BITS] = k;
        w[L_LSB +: GAIN_BITS] = len;
        return w;
    endfunction

    // receiver: random stalls, compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                relaxed_t exp_w;
                if (relaxed_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word %h", m_tdata);
                end else begin
                    exp_w = relaxed_q.pop_front();
                    checked++;
                    if (m_tdata[VEC_BITS-1:0] !== exp_w.first ||
                        m_tdata[2*VEC_BITS-1:VEC_BITS] !== exp_w.second ||
                        m_tuser[0] !== exp_w.fault || m_tuser[1] !== exp_w.sat) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %h %h f%b s%b got %h %h f%b s%b",
                                exp_w.first, exp_w.second, exp_w.fault, exp_w.sat,
                                m_tdata[VEC_BITS-1:0], m_tdata[2*VEC_BITS-1:VEC_BITS],
                                m_tuser[0], m_tuser[1]);
                    end
                end
            end
            if (rx_long) begin
                m_tready <= 1'b1;
            end else if (rx_hold > 0) begin
                // long receiver stall in progress
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) == 0) begin
                rx_hold  <= $urandom_range(10, 60);
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 9) != 0);
            end
        end
    end

    task automatic wait_drained();
        while (relaxed_q.size() != 0) @(posedge aclk);
    endtask

    // extremes of coordinates and gains, zero denominator, zero difference
    task automatic test_directed();
        logic [VEC_BITS-1:0] mx, mn, z;
        logic [GAIN_BITS-1:0] gmax;
        mx = {3{16'h7fff}};
        mn = {3{16'h8000}};
        z = '0;
        gmax = '1;
        send_spring(pack_spring(z, z, z, z, 24'h0, 24'h0, 24'h0));
        send_spring(pack_spring(z, z, mx, mn, 24'h0, 24'h0, gmax));
        send_spring(pack_spring(z, z, mx, mn, 24'h0, 24'h1000, gmax));
        send_spring(pack_spring(z, z, mx, mx, 24'h1000, 24'h1000, 24'h1000));
        send_spring(pack_spring(mn, mx, mx, mn, gmax, gmax, gmax));
        send_spring(pack_spring(mx, mn, mn, mx, gmax, gmax, gmax));
        send_spring(pack_spring(mx, mx, mn, mn, 24'h1, 24'h0, 24'h0));
        send_spring(pack_spring(z, z, 48'h400, z, 24'h1000, 24'h1000, 24'h1000));
        send_spring(pack_spring(z, z, 48'h400, z, 24'h1, gmax, gmax));
        send_spring(pack_spring(z, z, 48'h1, z, gmax, 24'h0, 24'h0));
        send_spring(pack_spring(mn, mn, mn, mn, 24'h800, 24'h0, gmax));
        send_spring(pack_spring(z, mx, z, mx, gmax, 24'h1, 24'h1));
        send_spring(pack_spring(z, z, 48'h400, z, 24'h2, gmax, gmax));
        end_burst();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            int mode, spread;
            logic [GAIN_BITS-1:0] rho, k, len;
            mode = $urandom_range(0, 9);
            spread = (mode < 6) ? $urandom_range(1, 4000) : 0;
            rho = (mode == 7) ? GAIN_BITS'(0) :
                  (mode < 5 ? GAIN_BITS'($urandom_range(0, 24'h10000)) : GAIN_BITS'($urandom));
            k   = (mode == 8) ? GAIN_BITS'(0) :
                  (mode < 5 ? GAIN_BITS'($urandom_range(0, 24'h10000)) : GAIN_BITS'($urandom));
            len = (mode < 5) ? GAIN_BITS'($urandom_range(0, 24'h8000)) : GAIN_BITS'($urandom);
            if (mode == 9 && $urandom_range(0, 1)) begin
                rho = '0;
                k = '0;
            end
            send_spring(pack_spring(rnd_vec(spread), rnd_vec(spread), rnd_vec(spread),
                                    rnd_vec(spread), rho, k, len));
        end
        end_burst();
    endtask

    // sender holds off until the pipeline is empty, then a burst with no receiver stall
    task automatic test_drain_burst();
        wait_drained();
        rx_long = 1;
        for (int i = 0; i < 80; i++) begin
            s_tvalid <= 1'b1;
            s_tdata <= pack_spring(rnd_vec(0), rnd_vec(0), rnd_vec(0), rnd_vec(0),
                                   GAIN_BITS'($urandom), GAIN_BITS'($urandom),
                                   GAIN_BITS'($urandom));
            @(posedge aclk);
            relaxed_q.push_back(relax_spring(s_tdata));
            while (!s_tready) @(posedge aclk);
            sent++;
        end
        rx_long = 0;
        end_burst();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(900);
        test_drain_burst();
        test_random(900);
        wait_drained();
        repeat (LATENCY + 20) @(posedge aclk);
        $display("sent %0d springs, checked %0d results (extremes, faults, random, burst)",
                 sent, checked);
        if (errors == 0 && relaxed_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
